// ----- rtl/hng_pkg.sv -----
// Shared types and constants of the heightmap normal generator.
package hng_pkg;

   localparam int MaxWidth   = 1024;
   localparam int ColBits    = 10;
   localparam int RowBits    = 12;
   localparam int SampleBits = 16;

   localparam logic [10:0] WIDTH_MAX  = 11'd1024;
   localparam logic [12:0] COUNT_MAX  = 13'd4096;
   localparam logic [10:0] WIDTH_RST  = 11'd256;
   localparam logic [12:0] COUNT_RST  = 13'd256;

   // Configuration register indexes.
   localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT = 2'd1;

   // The constant 2.0 in units of 2^-8, and its square.
   localparam logic [15:0] Y_TERM    = 16'd512;
   localparam logic [33:0] Y_TERM_SQ = 34'd262144;

   typedef struct packed {
      logic [SampleBits-1:0] hl;
      logic [SampleBits-1:0] hr;
      logic [SampleBits-1:0] hd;
      logic [SampleBits-1:0] hu;
      logic [ColBits-1:0]    col;
      logic [RowBits-1:0]    row;
      logic                  run_last;
      logic                  frame_last;
   } job_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic [14:0]        normal_y;
      logic signed [15:0] normal_z;
      logic [ColBits-1:0] pixel_col;
      logic [RowBits-1:0] pixel_row;
      logic               run_last;
      logic               frame_last;
   } result_type;

endpackage

// ----- rtl/hng_front.sv -----
// Front end: configuration, raster counters, line buffers and job generation.
module hng_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [hng_pkg::SampleBits-1:0] req_height_sample,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [12:0]                    csr_wr_data,
   output logic                           job_push,
   output hng_pkg::job_type               job_data,
   input  logic                           job_full
);
   import hng_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_READ = 2'd1;
   localparam logic [1:0] F_EMIT = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [10:0] width_ff, width_in;
   logic [12:0] count_ff, count_in;
   logic [ColBits-1:0] col_ff, col_in;
   logic [RowBits-1:0] row_ff, row_in;
   logic [1:0]  bank_ff, bank_in;
   logic [2:0]  pend_ff, pend_in;

   // Latched item context; payload, no reset.
   logic [SampleBits-1:0] smp_ff;
   logic [ColBits-1:0]    c_ff;
   logic [RowBits-1:0]    r_ff;
   logic [1:0]            curb_ff, prevb_ff, oldb_ff;
   logic                  r0_ff, r1_ff, lastcol_ff;
   logic [SampleBits-1:0] a_l_ff, a_r_ff, a_d_ff, b_l_ff, b_self_ff, c_d_ff;

   logic [SampleBits-1:0] mem [3*MaxWidth];
   logic [SampleBits-1:0] rd_data_ff;
   logic [11:0]           rd_addr;
   logic                  accept;

   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [10:0] col_inc;
   logic [12:0] row_inc;
   logic        lastrow, lastcol;
   logic [1:0]  prevb, oldb;
   logic [ColBits-1:0] cl, cr, cl2;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == 11'd0) w_eff = 11'd1;
      else if (width_ff > WIDTH_MAX) w_eff = WIDTH_MAX;
      h_eff = count_ff;
      if (count_ff == 13'd0) h_eff = 13'd1;
      else if (count_ff > COUNT_MAX) h_eff = COUNT_MAX;
   end

   assign req_full = (state_ff != F_IDLE);
   assign accept   = req_push && !req_full;
   assign col_inc  = {1'b0, col_ff} + 11'd1;
   assign row_inc  = {1'b0, row_ff} + 13'd1;
   assign lastcol  = (col_inc == w_eff);
   assign lastrow  = (row_inc == h_eff);
   assign prevb    = (bank_ff == 2'd0) ? 2'd2 : bank_ff - 2'd1;
   assign oldb     = (prevb == 2'd0) ? 2'd2 : prevb - 2'd1;

   // Neighbor columns of the latched pixel, clamped to the row.
   assign cl  = (c_ff == '0) ? '0 : c_ff - 1'b1;
   assign cr  = lastcol_ff ? c_ff : c_ff + 1'b1;
   assign cl2 = (c_ff <= 10'd1) ? '0 : c_ff - 10'd2;

   always_comb begin
      case (step_ff)
         3'd0:    rd_addr = {prevb_ff, cl};
         3'd1:    rd_addr = {prevb_ff, cr};
         3'd2:    rd_addr = {(r1_ff ? prevb_ff : oldb_ff), c_ff};
         3'd3:    rd_addr = {curb_ff, cl2};
         3'd4:    rd_addr = {curb_ff, cl};
         default: rd_addr = {prevb_ff, c_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[{bank_ff, col_ff}] <= req_height_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      width_in = width_ff;
      count_in = count_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      bank_in  = bank_ff;
      pend_in  = pend_ff;
      job_push = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_READ;
               step_in  = 3'd0;
               pend_in  = {lastrow && lastcol, lastrow && (col_ff != '0), row_ff != '0};
               if (lastcol) begin
                  col_in  = '0;
                  row_in  = lastrow ? '0 : row_inc[RowBits-1:0];
                  bank_in = (bank_ff == 2'd2) ? 2'd0 : bank_ff + 2'd1;
               end else begin
                  col_in = col_inc[ColBits-1:0];
               end
            end
         end
         F_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) state_in = F_EMIT;
         end
         F_EMIT: begin
            if (pend_ff == 3'd0) begin
               state_in = F_IDLE;
            end else if (!job_full) begin
               job_push = 1'b1;
               if (pend_ff[0]) pend_in[0] = 1'b0;
               else if (pend_ff[1]) pend_in[1] = 1'b0;
               else pend_in[2] = 1'b0;
            end
         end
         default: state_in = F_IDLE;
      endcase
      if (csr_wr_en) begin
         if (csr_index == REG_ROW_WIDTH) begin
            width_in = csr_wr_data[10:0];
            col_in   = '0;
            row_in   = '0;
         end else if (csr_index == REG_ROW_COUNT) begin
            count_in = csr_wr_data;
            col_in   = '0;
            row_in   = '0;
         end
      end
   end

   always_comb begin
      job_data            = '0;
      job_data.frame_last = 1'b0;
      if (pend_ff[0]) begin
         job_data.hl       = a_l_ff;
         job_data.hr       = a_r_ff;
         job_data.hd       = a_d_ff;
         job_data.hu       = smp_ff;
         job_data.col      = c_ff;
         job_data.row      = r_ff - 1'b1;
         job_data.run_last = (pend_ff[2:1] == 2'b00);
      end else if (pend_ff[1]) begin
         job_data.hl       = b_l_ff;
         job_data.hr       = smp_ff;
         job_data.hd       = r0_ff ? b_self_ff : a_l_ff;
         job_data.hu       = b_self_ff;
         job_data.col      = cl;
         job_data.row      = r_ff;
         job_data.run_last = !pend_ff[2];
      end else begin
         job_data.hl         = (c_ff != '0) ? b_self_ff : smp_ff;
         job_data.hr         = smp_ff;
         job_data.hd         = r0_ff ? smp_ff : c_d_ff;
         job_data.hu         = smp_ff;
         job_data.col        = c_ff;
         job_data.row        = r_ff;
         job_data.run_last   = 1'b1;
         job_data.frame_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 3'd0;
         width_ff <= WIDTH_RST;
         count_ff <= COUNT_RST;
         col_ff   <= '0;
         row_ff   <= '0;
         bank_ff  <= 2'd0;
         pend_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         width_ff <= width_in;
         count_ff <= count_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         bank_ff  <= bank_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff     <= req_height_sample;
         c_ff       <= col_ff;
         r_ff       <= row_ff;
         curb_ff    <= bank_ff;
         prevb_ff   <= prevb;
         oldb_ff    <= oldb;
         r0_ff      <= (row_ff == '0);
         r1_ff      <= (row_ff == 12'd1);
         lastcol_ff <= lastcol;
      end
      if (state_ff == F_READ) begin
         case (step_ff)
            3'd1:    a_l_ff    <= rd_data_ff;
            3'd2:    a_r_ff    <= rd_data_ff;
            3'd3:    a_d_ff    <= rd_data_ff;
            3'd4:    b_l_ff    <= rd_data_ff;
            3'd5:    b_self_ff <= rd_data_ff;
            3'd6:    c_d_ff    <= rd_data_ff;
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/hng_jobq.sv -----
// Four-entry queue of normal jobs between the front and back ends.
module hng_jobq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hng_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output hng_pkg::job_type pop_data,
   output logic             empty
);
   import hng_pkg::*;

   job_type    slot_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, do_push} - {2'd0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/hng_mag.sv -----
// Iterative unit: rounded m * 2^14 / sqrt(s) by long division and square root.
module hng_mag (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] m,
   input  logic [33:0] s,
   output logic        done,
   output logic [14:0] q
);
   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_MUL  = 3'd1;
   localparam logic [2:0] M_DIV  = 3'd2;
   localparam logic [2:0] M_SQRT = 3'd3;
   localparam logic [2:0] M_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] m_ff;
   logic [33:0] s_ff;
   logic        lsb_ff;
   logic [33:0] rem_ff;
   logic [30:0] quo_ff;
   logic [31:0] x_ff;
   logic [15:0] root_ff;
   logic [19:0] srem_ff;

   logic [31:0] prod;
   logic [34:0] sh, diff;
   logic        div_ge;
   logic [19:0] t, trial;
   logic        sq_ge;
   logic [16:0] qsum;

   assign prod   = m_ff * m_ff;
   assign sh     = {rem_ff, (cnt_ff == 5'd0) ? lsb_ff : 1'b0};
   assign diff   = sh - {1'b0, s_ff};
   assign div_ge = (sh >= {1'b0, s_ff});
   assign t      = {srem_ff[17:0], x_ff[31:30]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign sq_ge  = (t >= trial);
   assign qsum   = {1'b0, root_ff} + 17'd1;
   assign q      = qsum[15:1];
   assign done   = (state_ff == M_DONE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         M_IDLE: if (start) state_in = M_MUL;
         M_MUL: begin
            state_in = M_DIV;
            cnt_in   = 5'd0;
         end
         M_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               state_in = M_SQRT;
               cnt_in   = 5'd0;
            end
         end
         M_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) state_in = M_DONE;
         end
         M_DONE:  state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               m_ff <= m;
               s_ff <= s;
            end
         end
         M_MUL: begin
            // The dividend m^2 * 2^30 starts with its upper bits already in place.
            rem_ff <= {3'b000, prod[31:1]};
            lsb_ff <= prod[0];
            quo_ff <= '0;
         end
         M_DIV: begin
            rem_ff <= div_ge ? diff[33:0] : sh[33:0];
            quo_ff <= {quo_ff[29:0], div_ge};
            if (cnt_ff == 5'd30) begin
               x_ff    <= {1'b0, quo_ff[29:0], div_ge};
               root_ff <= '0;
               srem_ff <= '0;
            end
         end
         M_SQRT: begin
            srem_ff <= sq_ge ? t - trial : t;
            root_ff <= {root_ff[14:0], sq_ge};
            x_ff    <= {x_ff[29:0], 2'b00};
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/hng_back.sv -----
// Back end: forms the gradient vector of a job and normalizes its components.
module hng_back (
   input  logic                clock,
   input  logic                reset,
   output logic                job_pop,
   input  hng_pkg::job_type    job_data,
   input  logic                job_empty,
   output logic                rsp_valid,
   output hng_pkg::result_type rsp_data,
   input  logic                rsp_take
);
   import hng_pkg::*;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_DIFF  = 3'd1;
   localparam logic [2:0] B_SQX   = 3'd2;
   localparam logic [2:0] B_SUM   = 3'd3;
   localparam logic [2:0] B_START = 3'd4;
   localparam logic [2:0] B_WAIT  = 3'd5;
   localparam logic [2:0] B_OUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  comp_ff, comp_in;
   logic        valid_ff, valid_in;

   job_type            job_ff;
   logic signed [16:0] dx_ff, dz_ff;
   logic [31:0]        sqx_ff;
   logic [33:0]        s_ff;
   logic [14:0]        qx_ff, qy_ff, qz_ff;
   result_type         out_ff;

   logic [15:0] mx, mz, mag_m;
   logic [31:0] mz_sq;
   logic        mag_done;
   logic [14:0] mag_q;
   logic [16:0] dx_abs, dz_abs;

   assign dx_abs = dx_ff[16] ? -dx_ff : dx_ff;
   assign dz_abs = dz_ff[16] ? -dz_ff : dz_ff;
   assign mx     = dx_abs[15:0];
   assign mz     = dz_abs[15:0];
   assign mz_sq  = mz * mz;

   always_comb begin
      case (comp_ff)
         2'd0:    mag_m = mx;
         2'd1:    mag_m = Y_TERM;
         default: mag_m = mz;
      endcase
   end

   hng_mag u_mag (
      .clock (clock),
      .reset (reset),
      .start (state_ff == B_START),
      .m     (mag_m),
      .s     (s_ff),
      .done  (mag_done),
      .q     (mag_q)
   );

   assign job_pop   = (state_ff == B_IDLE) && !job_empty;
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      comp_in  = comp_ff;
      valid_in = valid_ff && !rsp_take;
      case (state_ff)
         B_IDLE:  if (!job_empty) state_in = B_DIFF;
         B_DIFF:  state_in = B_SQX;
         B_SQX:   state_in = B_SUM;
         B_SUM: begin
            state_in = B_START;
            comp_in  = 2'd0;
         end
         B_START: state_in = B_WAIT;
         B_WAIT: begin
            if (mag_done) begin
               if (comp_ff == 2'd2) begin
                  state_in = B_OUT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = B_START;
               end
            end
         end
         B_OUT: begin
            if (!valid_ff) begin
               valid_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         comp_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job_data;
      if (state_ff == B_DIFF) begin
         dx_ff <= $signed({1'b0, job_ff.hl}) - $signed({1'b0, job_ff.hr});
         dz_ff <= $signed({1'b0, job_ff.hd}) - $signed({1'b0, job_ff.hu});
      end
      if (state_ff == B_SQX) sqx_ff <= mx * mx;
      if (state_ff == B_SUM) s_ff <= {2'b00, sqx_ff} + {2'b00, mz_sq} + Y_TERM_SQ;
      if (state_ff == B_WAIT && mag_done) begin
         case (comp_ff)
            2'd0:    qx_ff <= mag_q;
            2'd1:    qy_ff <= mag_q;
            default: qz_ff <= mag_q;
         endcase
      end
      if (state_ff == B_OUT && !valid_ff) begin
         out_ff.normal_x   <= dx_ff[16] ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
         out_ff.normal_y   <= qy_ff;
         out_ff.normal_z   <= dz_ff[16] ? -$signed({1'b0, qz_ff}) : $signed({1'b0, qz_ff});
         out_ff.pixel_col  <= job_ff.col;
         out_ff.pixel_row  <= job_ff.row;
         out_ff.run_last   <= job_ff.run_last;
         out_ff.frame_last <= job_ff.frame_last;
      end
   end

endmodule

// ----- rtl/heightmap_normal_generator_top.sv -----
// Top level of the heightmap normal generator: front end, job queue and back end.
//
//   channel   direction  handshake              payload
//   req_      in         req_push / req_full    req_height_sample
//   rsp_      out        rsp_pop / rsp_empty    normal x/y/z, pixel col/row, run/frame last
//   csr_      in         csr_wr_en              csr_index, csr_wr_data
//
// The front end takes one sample beat at a time: it accepts the beat and writes the
// line buffer, makes six reads from its single read port and captures the last, pushes
// each job it queues, and returns to idle; req_full holds off new beats until then.
// Each normal takes the back end through setup, three components in turn through the
// shared divide and square root unit, and output; it pops no new job until then, which
// sets the sustained rate.
// Reset is synchronous and clears control state only; the line buffers hold no reset
// value and need no clearing pass. The four-entry job queue and the output register
// let the front end keep taking samples while a result waits to be popped.
module heightmap_normal_generator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_height_sample,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_normal_x,
   output logic [14:0]        rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic [9:0]         rsp_pixel_col,
   output logic [11:0]        rsp_pixel_row,
   output logic               rsp_run_last,
   output logic               rsp_frame_last,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wr_data
);
   import hng_pkg::*;

   logic       fq_push, fq_full, bq_pop, bq_empty;
   job_type    fq_data, bq_data;
   logic       out_valid;
   result_type out_data;

   // Sample intake, counters and line buffers.
   hng_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_height_sample (req_height_sample),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .job_push          (fq_push),
      .job_data          (fq_data),
      .job_full          (fq_full)
   );

   // Jobs wait here so the two halves stall independently.
   hng_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_data),
      .full      (fq_full),
      .pop       (bq_pop),
      .pop_data  (bq_data),
      .empty     (bq_empty)
   );

   // Normalization and the output register.
   hng_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_pop   (bq_pop),
      .job_data  (bq_data),
      .job_empty (bq_empty),
      .rsp_valid (out_valid),
      .rsp_data  (out_data),
      .rsp_take  (rsp_pop)
   );

   assign rsp_empty      = !out_valid;
   assign rsp_normal_x   = out_data.normal_x;
   assign rsp_normal_y   = out_data.normal_y;
   assign rsp_normal_z   = out_data.normal_z;
   assign rsp_pixel_col  = out_data.pixel_col;
   assign rsp_pixel_row  = out_data.pixel_row;
   assign rsp_run_last   = out_data.run_last;
   assign rsp_frame_last = out_data.frame_last;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the heightmap normal generator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hng_pkg::*;

   // A row of the directed table: a register write or one sample beat. Rows with
   // has_want carry the expected normal typed in by hand (flat one-pixel frames).
   typedef struct {
      bit          is_cfg;
      logic [1:0]  index;
      logic [15:0] value;
      bit          has_want;
      result_type  want;
   } stim_row;

   localparam result_type FlatLast = '{normal_x: 16'sd0, normal_y: 15'd16384,
      normal_z: 16'sd0, pixel_col: '0, pixel_row: '0, run_last: 1'b1, frame_last: 1'b1};
   localparam result_type NoWant = '{default: '0};
   localparam int unsigned CycleLimit = 1500000;
   localparam int DrainCycles = 600;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [15:0]        req_height_sample;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [15:0] rsp_normal_x;
   logic [14:0]        rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic [9:0]         rsp_pixel_col;
   logic [11:0]        rsp_pixel_row;
   logic               rsp_run_last;
   logic               rsp_frame_last;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [12:0]        csr_wr_data;

   heightmap_normal_generator_top u_dut (.*);

   // Shadow copy of the block: line buffers, counters and registers.
   logic [15:0] line_cur[MaxWidth];
   logic [15:0] line_prev[MaxWidth];
   logic [15:0] line_older[MaxWidth];
   int unsigned shadow_col, shadow_row;
   logic [10:0] shadow_width;
   logic [12:0] shadow_count;

   result_type  normals_due[$];
   int          fail_count;
   int unsigned cycle_count;
   int          items_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
      fail_count++;
   endtask

   // Largest q in 0..16384 with (2q-1)^2 * s <= m^2 * 2^30: the magnitude
   // m / sqrt(s) in Q1.14, rounded to nearest with ties away from zero.
   function automatic int unsigned q14_magnitude(longint unsigned m, longint unsigned s);
      logic [127:0] bound, prod, t;
      int unsigned  lo, hi, mid;
      bound = 128'(m) * 128'(m);
      bound = bound << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         t = 128'(2 * mid - 1);
         prod = t * t * 128'(s);
         if (prod <= bound) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic logic signed [15:0] q14_signed(longint d, longint unsigned s);
      int unsigned q;
      q = q14_magnitude(d < 0 ? -d : d, s);
      return d < 0 ? -16'(q) : 16'(q);
   endfunction

   function automatic result_type surface_normal(int hl, int hr, int hd, int hu,
                                                 int unsigned col, int unsigned row);
      result_type   n;
      longint       dx, dz;
      longint unsigned s;
      dx = hl - hr;
      dz = hd - hu;
      s = dx * dx + dz * dz + 512 * 512;
      n.normal_x   = q14_signed(dx, s);
      n.normal_y   = 15'(q14_magnitude(512, s));
      n.normal_z   = q14_signed(dz, s);
      n.pixel_col  = 10'(col);
      n.pixel_row  = 12'(row);
      n.run_last   = 1'b0;
      n.frame_last = 1'b0;
      return n;
   endfunction

   // Normals caused by one accepted sample, in output order; advances the shadow.
   task automatic predict_sample(logic [15:0] smp, output result_type outs[$]);
      int unsigned w, h, c, r, cl, cr, p;
      logic [15:0] hd, self_h, hl;
      result_type  n;
      outs = {};
      w = shadow_width == 0 ? 1 : (shadow_width > WIDTH_MAX ? MaxWidth : shadow_width);
      h = shadow_count == 0 ? 1 : (shadow_count > COUNT_MAX ? 4096 : shadow_count);
      if (shadow_col >= w) shadow_col = 0;
      if (shadow_row >= h) shadow_row = 0;
      c = shadow_col;
      r = shadow_row;
      line_cur[c] = smp;
      if (r >= 1) begin
         cl = c > 0 ? c - 1 : 0;
         cr = c + 1 < w ? c + 1 : w - 1;
         hd = (r == 1) ? line_prev[c] : line_older[c];
         outs = {outs, surface_normal(line_prev[cl], line_prev[cr], hd, smp, c, r - 1)};
      end
      if (r == h - 1) begin
         // Bottom row: the pixel to the left now has its right neighbor.
         if (c >= 1) begin
            p = c - 1;
            cl = p > 0 ? p - 1 : 0;
            self_h = line_cur[p];
            hd = r == 0 ? self_h : line_prev[p];
            outs = {outs, surface_normal(line_cur[cl], smp, hd, self_h, p, r)};
         end
         if (c == w - 1) begin
            hl = c >= 1 ? line_cur[c - 1] : smp;
            hd = r == 0 ? smp : line_prev[c];
            n = surface_normal(hl, smp, hd, smp, c, r);
            n.frame_last = 1'b1;
            outs = {outs, n};
         end
      end
      if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
      c++;
      if (c >= w) begin
         c = 0;
         line_older = line_prev;
         line_prev = line_cur;
         r++;
         if (r >= h) r = 0;
      end
      shadow_col = c;
      shadow_row = r;
   endtask

   // Pushes one sample beat after a random gap; req_push stays high across
   // back-to-back beats.
   task automatic send_sample(logic [15:0] smp, bit has_want, result_type want);
      int          gap;
      result_type  outs[$];
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_height_sample <= smp;
      do @(posedge clock); while (req_full);
      predict_sample(smp, outs);
      if (has_want && outs.size() == 1) outs[0] = want;
      normals_due = {normals_due, outs};
      items_sent++;
   endtask

   // Register writes happen only with nothing in flight.
   task automatic write_reg(logic [1:0] index, logic [12:0] value);
      req_push <= 1'b0;
      @(posedge clock);
      while (normals_due.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == REG_ROW_WIDTH) shadow_width = value[10:0];
      else shadow_count = value;
      shadow_col = 0;
      shadow_row = 0;
   endtask

   // Result side: random pop stalls, with quiet stretches where pop stays high.
   initial begin
      int stall, beats;
      beats = 0;
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         stall = ((beats / 32) % 3 == 0) ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         beats++;
      end
   end

   // Checks each popped beat against the oldest pending normal.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (normals_due.size() == 0) begin
            report_mismatch("pending normals at a result beat", 0, 1);
         end else begin
            want = normals_due.pop_front();
            if (rsp_normal_x !== want.normal_x)
               report_mismatch("normal_x", rsp_normal_x, want.normal_x);
            if (rsp_normal_y !== want.normal_y)
               report_mismatch("normal_y", rsp_normal_y, want.normal_y);
            if (rsp_normal_z !== want.normal_z)
               report_mismatch("normal_z", rsp_normal_z, want.normal_z);
            if (rsp_pixel_col !== want.pixel_col)
               report_mismatch("pixel_col", rsp_pixel_col, want.pixel_col);
            if (rsp_pixel_row !== want.pixel_row)
               report_mismatch("pixel_row", rsp_pixel_row, want.pixel_row);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
            if (rsp_frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_frame_last, want.frame_last);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   stim_row directed[] = '{
      // One-pixel frames: every neighbor is the pixel itself, so the normal is flat.
      '{1'b1, REG_ROW_WIDTH, 16'd1,     1'b0, NoWant},
      '{1'b1, REG_ROW_COUNT, 16'd1,     1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0000,  1'b1, FlatLast},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFF,  1'b1, FlatLast},
      // Zero in either register is taken as one.
      '{1'b1, REG_ROW_WIDTH, 16'd0,     1'b0, NoWant},
      '{1'b1, REG_ROW_COUNT, 16'd0,     1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h8000,  1'b1, FlatLast},
      // Oversized values clamp to the maximum; a few samples of the top row only.
      '{1'b1, REG_ROW_WIDTH, 16'd2047,  1'b0, NoWant},
      '{1'b1, REG_ROW_COUNT, 16'd8191,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0000,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFF,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0001,  1'b0, NoWant},
      '{1'b1, REG_ROW_WIDTH, 16'd1024,  1'b0, NoWant},
      '{1'b1, REG_ROW_COUNT, 16'd4096,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h5555,  1'b0, NoWant},
      // Full 3x2 frame with steepest slopes both ways.
      '{1'b1, REG_ROW_WIDTH, 16'd3,     1'b0, NoWant},
      '{1'b1, REG_ROW_COUNT, 16'd2,     1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0000,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFF,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0000,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFF,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0000,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFF,  1'b0, NoWant},
      // 2x3 frame: the middle row reads the older line buffer.
      '{1'b1, REG_ROW_WIDTH, 16'd2,     1'b0, NoWant},
      '{1'b1, REG_ROW_COUNT, 16'd3,     1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hAAAA,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h5555,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFF,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0000,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'h0001,  1'b0, NoWant},
      '{1'b0, REG_ROW_WIDTH, 16'hFFFE,  1'b0, NoWant}
   };

   // Main sequence: reset, directed table, random frames, drain and verdict.
   initial begin
      int          w, h, frames, total, stop_at;
      logic [15:0] level;
      fail_count        = 0;
      items_sent        = 0;
      shadow_width      = WIDTH_RST;
      shadow_count      = COUNT_RST;
      shadow_col        = 0;
      shadow_row        = 0;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_height_sample = '0;
      csr_wr_en         = 1'b0;
      csr_index         = REG_ROW_WIDTH;
      csr_wr_data       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_cfg)
            write_reg(directed[i].index, directed[i].value[12:0]);
         else
            send_sample(directed[i].value, directed[i].has_want, directed[i].want);
      end

      // Random frames, mostly small. Heights are mostly smooth terrain walks with
      // some full-range noise; now and then a frame is cut short by a new setting.
      level = 16'(($urandom));
      while (items_sent < 430) begin
         w = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         h = $urandom_range(1, 5);
         if ($urandom_range(0, 1)) write_reg(REG_ROW_WIDTH, 13'(w));
         else write_reg(REG_ROW_WIDTH, 13'(w) | 13'h1800 & 13'(($urandom_range(0, 1)) << 12));
         write_reg(REG_ROW_COUNT, 13'(h));
         frames = $urandom_range(1, 2);
         total = w * h * frames;
         stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
         for (int k = 0; k < stop_at; k++) begin
            if ($urandom_range(0, 2) == 0)
               level = 16'($urandom);
            else
               level = 16'(int'(level) + $urandom_range(0, 2048) - 1024);
            send_sample(level, 1'b0, NoWant);
         end
      end

      req_push <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && normals_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- heightmap_normal_generator_top.f -----
rtl/hng_pkg.sv
rtl/hng_front.sv
rtl/hng_jobq.sv
rtl/hng_mag.sv
rtl/hng_back.sv
rtl/heightmap_normal_generator_top.sv
sim/testbench.sv
